>>> sv/kwl_pkg.sv
`default_nettype none
package kwl_pkg;

  localparam int POS_BITS     = 16;
  localparam int PREFIX_CHARS = 8;
  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_NAME  = 3'd1;
  localparam logic [2:0] M_FIRST = 3'd2;
  localparam logic [2:0] M_WORD  = 3'd3;
  localparam logic [2:0] M_TYPE  = 3'd4;
  localparam logic [2:0] M_INT   = 3'd5;
  localparam logic [2:0] M_STR   = 3'd6;

  localparam logic [4:0] KIND_AT      = 5'd0;
  localparam logic [4:0] KIND_NAME    = 5'd1;
  localparam logic [4:0] KIND_VAR     = 5'd2;
  localparam logic [4:0] KIND_WRITELN = 5'd3;
  localparam logic [4:0] KIND_RETURN  = 5'd4;
  localparam logic [4:0] KIND_MODULE  = 5'd5;
  localparam logic [4:0] KIND_IO      = 5'd6;
  localparam logic [4:0] KIND_READLN  = 5'd7;
  localparam logic [4:0] KIND_STRKW   = 5'd8;
  localparam logic [4:0] KIND_I32     = 5'd9;
  localparam logic [4:0] KIND_I64     = 5'd10;
  localparam logic [4:0] KIND_F32     = 5'd11;
  localparam logic [4:0] KIND_F64     = 5'd12;
  localparam logic [4:0] KIND_C8      = 5'd13;
  localparam logic [4:0] KIND_B8      = 5'd14;
  localparam logic [4:0] KIND_INT     = 5'd15;
  localparam logic [4:0] KIND_STRLIT  = 5'd16;
  localparam logic [4:0] KIND_SEMI    = 5'd17;
  localparam logic [4:0] KIND_LPAREN  = 5'd18;
  localparam logic [4:0] KIND_RPAREN  = 5'd19;
  localparam logic [4:0] KIND_LBRACE  = 5'd20;
  localparam logic [4:0] KIND_RBRACE  = 5'd21;
  localparam logic [4:0] KIND_COLON   = 5'd22;
  localparam logic [4:0] KIND_EQUAL   = 5'd23;

  // byte 0 of a lexeme sits in the low bits, so the text is spelled backward
  localparam logic [63:0] WORD_TEXT [6] = '{
    {8'h00,  "nLetirw"}, {16'h0000, "nruter"}, {16'h0000, "eludom"},
    {48'h0,  "oi"},      {16'h0000, "nLdaer"}, {16'h0000, "gnirts"}
  };
  localparam logic [3:0] WORD_LEN [6] = '{4'd7, 4'd6, 4'd6, 4'd2, 4'd6, 4'd6};
  localparam logic [4:0] WORD_KIND [6] = '{
    KIND_WRITELN, KIND_RETURN, KIND_MODULE, KIND_IO, KIND_READLN, KIND_STRKW
  };

  localparam logic [63:0] TYPE_TEXT [6] = '{
    {40'h0, "23i"}, {40'h0, "46i"}, {40'h0, "23f"},
    {40'h0, "46f"}, {48'h0, "8c"},  {48'h0, "8b"}
  };
  localparam logic [3:0] TYPE_LEN [6] = '{4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2};
  localparam logic [4:0] TYPE_KIND [6] = '{
    KIND_I32, KIND_I64, KIND_F32, KIND_F64, KIND_C8, KIND_B8
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  typedef struct packed {
    token_t a;
    logic   a_valid;
    token_t b;
    logic   b_valid;
  } push_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               has_room;
    logic               not_empty;
  } fifo_status_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [63:0] len_mask(logic [3:0] n);
    return ~(64'hFFFF_FFFF_FFFF_FFFF << {n[2:0], 3'b000});
  endfunction

  // returns {hit, kind}
  function automatic logic [5:0] word_lookup(logic [63:0] p, logic [15:0] n);
    logic [5:0] r;
    r = {1'b0, KIND_VAR};
    for (int t = 5; t >= 0; t--) begin
      if (n == 16'(WORD_LEN[t]) && (p & len_mask(WORD_LEN[t])) == WORD_TEXT[t]) begin
        r = {1'b1, WORD_KIND[t]};
      end
    end
    return r;
  endfunction

  function automatic logic [5:0] type_lookup(logic [63:0] p, logic [15:0] n);
    logic [5:0] r;
    r = {1'b0, KIND_VAR};
    for (int t = 5; t >= 0; t--) begin
      if (n == 16'(TYPE_LEN[t]) && (p & len_mask(TYPE_LEN[t])) == TYPE_TEXT[t]) begin
        r = {1'b1, TYPE_KIND[t]};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/keyword_token_lexer_unit.sv
// A token enters the token queue as the byte that ends it is taken, and is offered
// on the master side from that queue. One item per cycle while the queue has room;
// a two-token item writes both into the four-entry queue (input stalls below two free).
// Reset: synchronous, active high; clears lexer state, position and the token queue.
`default_nettype none
module keyword_token_lexer_unit
  import kwl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // char_byte
  input  wire logic        s_tuser,   // end_of_input
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // token_start, token_length
  output logic      [4:0]  m_tuser,   // token_kind
  output logic             m_tlast    // last_of_run
);

  logic         accept;
  logic         pop;
  push_t        push;
  token_t       head;
  fifo_status_t status;

  assign s_tready = status.has_room;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = status.not_empty;
  assign pop      = m_tvalid && m_tready;

  kwl_lex_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_byte    (s_tdata),
    .end_of_input (s_tuser),
    .push         (push)
  );

  kwl_token_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (status)
  );

  assign m_tdata = {head.length, head.start};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.b_valid |-> push.a_valid && push.b.last && !push.a.last)
    else $error("second token without first");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    push.a_valid && !push.b_valid |-> push.a.last)
    else $error("single token not marked last");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |-> !push.a_valid && !push.b_valid)
    else $error("token pushed without an accepted item");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    accept |=> status.level <= LEVEL_W'(FIFO_DEPTH))
    else $error("token queue overflow");

endmodule
`default_nettype wire

>>> sv/kwl_lex_core.sv
`default_nettype none
module kwl_lex_core
  import kwl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_input,
  output push_t           push
);

  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  logic [2:0]          lex_mode, lex_mode_next;
  logic [63:0]         prefix_chars, prefix_chars_next;
  logic [15:0]         run_length, run_length_next;
  logic [15:0]         run_start, run_start_next;
  logic [POS_BITS-1:0] stream_position, stream_position_next;
  logic                ignore_next_at, ignore_next_at_next;

  logic        extend;
  logic        close;
  logic        do_idle;
  logic        after_at;
  logic        close_valid;
  logic [4:0]  close_kind;
  logic        idle_valid;
  logic [4:0]  idle_kind;
  logic [5:0]  word_hit;
  logic [5:0]  type_hit;
  logic [63:0] ext_prefix;
  logic [15:0] cur_start;
  token_t      close_tok;
  token_t      idle_tok;

  assign word_hit  = word_lookup(prefix_chars, run_length);
  assign type_hit  = type_lookup(prefix_chars, run_length);
  assign cur_start = 16'(stream_position);

  always_comb begin
    ext_prefix = prefix_chars;
    if (run_length < 16'(PREFIX_CHARS)) begin
      ext_prefix[{run_length[2:0], 3'b000} +: 8] = char_byte;
    end
  end

  always_comb begin
    close_kind  = KIND_VAR;
    close_valid = 1'b1;
    case (lex_mode)
      M_NAME:  close_kind = KIND_NAME;
      M_FIRST: close_kind = KIND_VAR;
      M_WORD:  close_kind = word_hit[4:0];
      M_TYPE: begin
        close_kind  = type_hit[4:0];
        close_valid = type_hit[5];
      end
      M_INT:   close_kind = KIND_INT;
      M_STR:   close_kind = KIND_STRLIT;
      default: close_valid = 1'b0;
    endcase
  end

  always_comb begin
    lex_mode_next        = lex_mode;
    prefix_chars_next    = prefix_chars;
    run_length_next      = run_length;
    run_start_next       = run_start;
    stream_position_next = stream_position;
    ignore_next_at_next  = ignore_next_at;
    extend               = 1'b0;
    close                = 1'b0;
    do_idle              = 1'b0;
    after_at             = ignore_next_at;
    idle_valid           = 1'b0;
    idle_kind            = KIND_AT;

    if (accept && !end_of_input) begin
      stream_position_next = stream_position + POS_ONE;
      case (lex_mode)
        M_NAME: begin
          if (is_alpha(char_byte)) begin
            extend = 1'b1;
          end else begin
            close    = 1'b1;
            do_idle  = 1'b1;
            after_at = 1'b1;
          end
        end
        M_FIRST: begin
          if (is_digit(char_byte)) begin
            lex_mode_next = M_TYPE;
            extend        = 1'b1;
          end else if (is_alpha(char_byte)) begin
            lex_mode_next = M_WORD;
            extend        = 1'b1;
          end else begin
            close   = 1'b1;
            do_idle = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(char_byte)) begin
            extend = 1'b1;
          end else begin
            close   = 1'b1;
            do_idle = 1'b1;
          end
        end
        M_TYPE, M_INT: begin
          if (is_digit(char_byte)) begin
            extend = 1'b1;
          end else begin
            close   = 1'b1;
            do_idle = 1'b1;
          end
        end
        M_STR: begin
          if (char_byte == "\"") begin
            close = 1'b1;
          end else begin
            extend = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (extend && run_length != LEN_MAX) begin
        prefix_chars_next = ext_prefix;
        run_length_next   = run_length + 16'd1;
      end
      if (close || do_idle) begin
        lex_mode_next = M_IDLE;
      end

      if (do_idle) begin
        ignore_next_at_next = 1'b0;
        if (char_byte == "@") begin
          if (!after_at) begin
            idle_valid          = 1'b1;
            idle_kind           = KIND_AT;
            ignore_next_at_next = 1'b1;
          end
        end else if (is_alpha(char_byte) || is_digit(char_byte)) begin
          lex_mode_next     = is_digit(char_byte) ? M_INT : (after_at ? M_NAME : M_FIRST);
          run_start_next    = cur_start;
          run_length_next   = 16'd1;
          prefix_chars_next = {56'd0, char_byte};
        end else if (char_byte == "\"") begin
          lex_mode_next     = M_STR;
          run_start_next    = 16'(stream_position + POS_ONE);
          run_length_next   = 16'd0;
          prefix_chars_next = 64'd0;
        end else begin
          idle_valid = 1'b1;
          case (char_byte)
            ";":     idle_kind = KIND_SEMI;
            "(":     idle_kind = KIND_LPAREN;
            ")":     idle_kind = KIND_RPAREN;
            "{":     idle_kind = KIND_LBRACE;
            "}":     idle_kind = KIND_RBRACE;
            ":":     idle_kind = KIND_COLON;
            "=":     idle_kind = KIND_EQUAL;
            default: idle_valid = 1'b0;
          endcase
        end
      end
    end else if (accept) begin
      close                = 1'b1;
      lex_mode_next        = M_IDLE;
      prefix_chars_next    = 64'd0;
      run_length_next      = 16'd0;
      run_start_next       = 16'd0;
      stream_position_next = '0;
      ignore_next_at_next  = 1'b0;
    end
  end

  always_comb begin
    close_tok.kind   = close_kind;
    close_tok.start  = run_start;
    close_tok.length = run_length;
    close_tok.last   = !idle_valid;
    idle_tok.kind    = idle_kind;
    idle_tok.start   = cur_start;
    idle_tok.length  = 16'd1;
    idle_tok.last    = 1'b1;
    if (close && close_valid) begin
      push.a       = close_tok;
      push.a_valid = 1'b1;
      push.b       = idle_tok;
      push.b_valid = idle_valid;
    end else begin
      push.a       = idle_tok;
      push.a_valid = idle_valid;
      push.b       = idle_tok;
      push.b_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode        <= M_IDLE;
      prefix_chars    <= 64'd0;
      run_length      <= 16'd0;
      run_start       <= 16'd0;
      stream_position <= '0;
      ignore_next_at  <= 1'b0;
    end else begin
      lex_mode        <= lex_mode_next;
      prefix_chars    <= prefix_chars_next;
      run_length      <= run_length_next;
      run_start       <= run_start_next;
      stream_position <= stream_position_next;
      ignore_next_at  <= ignore_next_at_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/kwl_token_fifo.sv
`default_nettype none
module kwl_token_fifo
  import kwl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire push_t push,
  input  wire logic pop,
  output token_t    head,
  output fifo_status_t status
);

  token_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_next;

  always_comb begin
    level_next = level + LEVEL_W'(push.a_valid) + LEVEL_W'(push.b_valid) - LEVEL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      mem[wr_ptr] <= push.a;
    end
    if (push.b_valid) begin
      mem[wr_ptr + PTR_W'(push.a_valid)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.a_valid) + PTR_W'(push.b_valid);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      level  <= level_next;
    end
  end

  assign head             = mem[rd_ptr];
  assign status.level     = level;
  assign status.has_room  = level <= LEVEL_W'(FIFO_DEPTH - 2);
  assign status.not_empty = level != '0;

endmodule
`default_nettype wire
